FILE: src/sf_pkg.sv
// Shared types and constants for the sigma filter plane block.
// Holds register codes, fixed field widths and the sequencer state type.
// No dependencies; sigma_filter_plane imports this package.
package sf_pkg;

    // Fixed field widths.
    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int DIAM_W     = 4;
    localparam int STR_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERLACED   = 3'd4;

    // Register values after reset.
    localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = 12'd480;
    localparam logic [DIAM_W-1:0] RST_DIAMETER     = 4'd11;
    localparam logic [STR_W-1:0]  RST_STRENGTH     = 9'd200;

    // Input operation codes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Distance datapath: t = (strength+2)/3, v = t*t/3, dist = isqrt(v).
    // Division by three is a multiply by ceil(2^16/3) and a shift by 16.
    localparam int               RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP3    = 15'd21846;
    localparam int               RECIP_SHIFT = 16;
    localparam int               T_W         = 8;
    localparam int               SQ_W        = 16;
    localparam int               V_W         = 14;
    localparam int               DIST_W      = 7;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_CHECK,
        ST_DIST_T,
        ST_DIST_SQ,
        ST_DIST_D3,
        ST_DIST_RT,
        ST_CTR_RD,
        ST_CTR_LAT,
        ST_SCAN,
        ST_SCAN_END,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } sf_state_t;

endpackage

FILE: src/sigma_filter_plane.sv
// Sigma filter over one 8-bit plane; pixels arrive and leave in raster order.
// One item at a time: an item without a result ends after the readiness check;
// one with a result also takes sequencing, R*C reads of the single line-store
// read port (R*C the clipped window, up to 121), a serial divide and a free
// output register. A held result stalls the next result in place.
// Reset is synchronous, active low; it clears positions and state, loads the configuration
// reset values and leaves the line store. Depends on sf_pkg, sf_ram and sf_div.
module sigma_filter_plane #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_DIAMETER = 11,
    parameter int MAX_HEIGHT   = 4095
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [sf_pkg::PIX_W-1:0]        s_pixel_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sf_pkg::PIX_W-1:0]        m_filtered_value,
    output logic                            m_frame_done
);

    import sf_pkg::*;

    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int CW      = WW + 1;
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int RW      = HW + 2;
    localparam int RING    = 2 * (MAX_DIAMETER - 1) + 1;
    localparam int LW      = $clog2(RING);
    localparam int DEPTH   = RING * MAX_WIDTH;
    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_MAX = MAX_DIAMETER * MAX_DIAMETER;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int SUM_W   = $clog2(CNT_MAX * 255 + CNT_MAX / 2 + 1);
    localparam int WCMP_W  = ((WW > FW_W) ? WW : FW_W) + 1;
    localparam int HCMP_W  = ((HW > FH_W) ? HW : FH_W) + 1;

    // Configuration registers.
    logic [FW_W-1:0]   fw_reg;
    logic [FH_W-1:0]   fh_reg;
    logic [DIAM_W-1:0] diam_reg;
    logic [STR_W-1:0]  str_reg;
    logic              ilace_reg;

    // Sequencer and item registers.
    sf_state_t         state_reg, state_next;
    logic              op_reg;
    logic [PIX_W-1:0]  pix_reg;

    // Raster positions with their ring line numbers.
    logic [WW-1:0]     in_col_reg, out_col_reg;
    logic [RW-1:0]     in_row_reg, out_row_reg;
    logic [LW-1:0]     in_line_reg, out_line_reg;

    // Window scan registers.
    logic [RW-1:0]     row_reg, yhi_reg;
    logic [LW-1:0]     line_reg;
    logic [WW-1:0]     col_reg, xlo_reg, xhi_reg;
    logic              step2_reg;
    logic              pend_reg;

    // Distance and accumulation registers.
    logic [T_W-1:0]    t_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [V_W-1:0]    v_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [2:0]        bit_reg;
    logic [PIX_W-1:0]  centre_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // Output register.
    logic              m_valid_reg;
    logic [PIX_W-1:0]  m_val_reg;
    logic              m_done_reg;

    // Effective frame geometry after saturation.
    logic [WW-1:0]     w_eff;
    logic [HW-1:0]     h_eff;
    logic [DIAM_W-1:0] n_odd, n_eff, rad, nm1, look;

    // Ring line and address helpers.
    function automatic logic [LW-1:0] line_inc(input logic [LW-1:0] l);
        logic [LW:0] s;
        s = {1'b0, l} + 1'b1;
        if (s >= (LW+1)'(RING)) begin
            s = '0;
        end
        return s[LW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l,
                                              input logic [WW-1:0] c);
        return AW'(l) * AW'(MAX_WIDTH) + AW'(c);
    endfunction

    // Saturate the geometry registers into their legal ranges.
    always_comb begin
        if (fw_reg < FW_W'(16)) begin
            w_eff = WW'(16);
        end else if (WCMP_W'(fw_reg) > WCMP_W'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(fw_reg);
        end
        if (fh_reg == '0) begin
            h_eff = HW'(1);
        end else if (HCMP_W'(fh_reg) > HCMP_W'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(fh_reg);
        end
        n_odd = diam_reg | DIAM_W'(1);
        if (n_odd < DIAM_W'(3)) begin
            n_eff = DIAM_W'(3);
        end else if (n_odd > DIAM_W'(MAX_DIAMETER)) begin
            n_eff = DIAM_W'(MAX_DIAMETER);
        end else begin
            n_eff = n_odd;
        end
        rad  = n_eff >> 1;
        nm1  = n_eff - 1'b1;
        look = ilace_reg ? nm1 : rad;
    end

    // Position normalization and the line store write of a new pixel.
    logic [WW-1:0] nz_oc, nz_ic, wr_col;
    logic [RW-1:0] nz_or, nz_ir;
    logic [LW-1:0] nz_ol, nz_il, wr_line;
    logic          wr_en;

    always_comb begin
        nz_oc = out_col_reg;
        nz_or = out_row_reg;
        nz_ol = out_line_reg;
        nz_ic = in_col_reg;
        nz_ir = in_row_reg;
        nz_il = in_line_reg;
        wr_en = 1'b0;
        if (nz_oc >= w_eff) begin
            nz_oc = '0;
            nz_or = nz_or + 1'b1;
            nz_ol = line_inc(nz_ol);
        end
        if (nz_or >= RW'(h_eff)) begin
            nz_oc = '0;
            nz_or = '0;
            nz_ol = '0;
            nz_ic = '0;
            nz_ir = '0;
            nz_il = '0;
        end
        if (nz_ic >= w_eff) begin
            nz_ic = '0;
            nz_ir = nz_ir + 1'b1;
            nz_il = line_inc(nz_il);
        end
        wr_line = nz_il;
        wr_col  = nz_ic;
        if (state_reg == ST_NORM && op_reg == OP_PIXEL && nz_ir < RW'(h_eff)) begin
            wr_en = 1'b1;
            nz_ic = nz_ic + 1'b1;
            if (nz_ic >= w_eff) begin
                nz_ic = '0;
                nz_ir = nz_ir + 1'b1;
                nz_il = line_inc(nz_il);
            end
        end
    end

    // Readiness of the next output and the bounds of its window.
    logic [RW-1:0] yhi_c, ylo_c;
    logic [CW-1:0] xhi_w;
    logic [WW-1:0] xhi_c, xlo_c;
    logic [LW-1:0] k_c, start_line_c;
    logic [LW:0]   line_sum;
    logic          out_ready_c;

    always_comb begin
        yhi_c = out_row_reg + RW'(look);
        if (yhi_c > RW'(h_eff) - 1'b1) begin
            yhi_c = RW'(h_eff) - 1'b1;
        end
        xhi_w = CW'(out_col_reg) + CW'(rad);
        if (xhi_w > CW'(w_eff) - 1'b1) begin
            xhi_w = CW'(w_eff) - 1'b1;
        end
        xhi_c = xhi_w[WW-1:0];
        out_ready_c = (in_row_reg >= RW'(h_eff)) || (in_row_reg > yhi_c) ||
                      (in_row_reg == yhi_c && in_col_reg > xhi_c);
        if (ilace_reg) begin
            if (out_row_reg >= RW'(nm1)) begin
                ylo_c = out_row_reg - RW'(nm1);
            end else begin
                ylo_c = RW'(out_row_reg[0]);
            end
        end else begin
            if (out_row_reg >= RW'(rad)) begin
                ylo_c = out_row_reg - RW'(rad);
            end else begin
                ylo_c = '0;
            end
        end
        k_c = LW'(out_row_reg - ylo_c);
        if (out_line_reg >= k_c) begin
            line_sum = {1'b0, out_line_reg} - {1'b0, k_c};
        end else begin
            line_sum = {1'b0, out_line_reg} + (LW+1)'(RING) - {1'b0, k_c};
        end
        start_line_c = line_sum[LW-1:0];
        xlo_c = (out_col_reg >= WW'(rad)) ? out_col_reg - WW'(rad) : '0;
    end

    // Window scan stepping.
    logic [RW-1:0] row_step;
    logic [LW:0]   line_step;
    logic [LW-1:0] line_adv;
    logic          scan_last;

    always_comb begin
        row_step  = row_reg + (step2_reg ? RW'(2) : RW'(1));
        line_step = {1'b0, line_reg} + (step2_reg ? (LW+1)'(2) : (LW+1)'(1));
        if (line_step >= (LW+1)'(RING)) begin
            line_step = line_step - (LW+1)'(RING);
        end
        line_adv  = line_step[LW-1:0];
        scan_last = (col_reg == xhi_reg) && (row_step > yhi_reg);
    end

    // Distance datapath terms.
    logic [STR_W+RECIP_W:0]  t_prod;
    logic [SQ_W+RECIP_W-1:0] v_prod;
    logic [DIST_W-1:0]       trial;
    logic [2*DIST_W-1:0]     trial_sq;

    always_comb begin
        t_prod   = (STR_W+RECIP_W+1)'(({1'b0, str_reg} + 1'b1 + 1'b1)) *
                   (STR_W+RECIP_W+1)'(RECIP3);
        v_prod   = (SQ_W+RECIP_W)'(sq_reg) * (SQ_W+RECIP_W)'(RECIP3);
        trial    = dist_reg | (DIST_W'(1) << bit_reg);
        trial_sq = (2*DIST_W)'(trial) * (2*DIST_W)'(trial);
    end

    // Line store.
    logic [AW-1:0]    rd_addr;
    logic [PIX_W-1:0] rd_data;

    sf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (addr_of(wr_line, wr_col)),
        .wr_data (pix_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Test of a window sample against the centre value.
    logic [PIX_W-1:0] diff;
    logic             in_range;

    always_comb begin
        diff     = (rd_data >= centre_reg) ? rd_data - centre_reg : centre_reg - rd_data;
        in_range = diff <= PIX_W'(dist_reg);
    end

    // Divider for the rounded mean.
    logic             div_start, div_done;
    logic [SUM_W-1:0] div_num, div_quo;
    logic [CNT_W-1:0] div_den;

    always_comb begin
        if (cnt_reg == '0) begin
            div_num = SUM_W'(centre_reg);
            div_den = CNT_W'(1);
        end else begin
            div_num = sum_reg + SUM_W'(cnt_reg >> 1);
            div_den = cnt_reg;
        end
    end

    sf_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic out_free;
    logic frame_last;
    assign out_free   = !m_valid_reg || m_ready;
    assign frame_last = (out_row_reg == RW'(h_eff) - 1'b1) &&
                        (out_col_reg == w_eff - 1'b1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_NORM;
            ST_NORM:      state_next = ST_CHECK;
            ST_CHECK:     state_next = out_ready_c ? ST_DIST_T : ST_IDLE;
            ST_DIST_T:    state_next = ST_DIST_SQ;
            ST_DIST_SQ:   state_next = ST_DIST_D3;
            ST_DIST_D3:   state_next = ST_DIST_RT;
            ST_DIST_RT:   if (bit_reg == '0) state_next = ST_CTR_RD;
            ST_CTR_RD:    state_next = ST_CTR_LAT;
            ST_CTR_LAT:   state_next = ST_SCAN;
            ST_SCAN:      if (scan_last) state_next = ST_SCAN_END;
            ST_SCAN_END:  state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_done) state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_DIV_START);
        if (state_reg == ST_SCAN) begin
            rd_addr = addr_of(line_reg, col_reg);
        end else begin
            rd_addr = addr_of(out_line_reg, out_col_reg);
        end
    end

    // Control registers: state, configuration, positions and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fw_reg       <= RST_FRAME_WIDTH;
            fh_reg       <= RST_FRAME_HEIGHT;
            diam_reg     <= RST_DIAMETER;
            str_reg      <= RST_STRENGTH;
            ilace_reg    <= 1'b0;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_line_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_line_reg <= '0;
            m_valid_reg  <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_SCAN);
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  fw_reg    <= cfg_data[FW_W-1:0];
                    CFG_FRAME_HEIGHT: fh_reg    <= cfg_data[FH_W-1:0];
                    CFG_DIAMETER:     diam_reg  <= cfg_data[DIAM_W-1:0];
                    CFG_STRENGTH:     str_reg   <= cfg_data[STR_W-1:0];
                    CFG_INTERLACED:   ilace_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (state_reg == ST_NORM) begin
                in_col_reg   <= nz_ic;
                in_row_reg   <= nz_ir;
                in_line_reg  <= nz_il;
                out_col_reg  <= nz_oc;
                out_row_reg  <= nz_or;
                out_line_reg <= nz_ol;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_OUT && out_free) begin
                if (frame_last) begin
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_line_reg  <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_line_reg <= '0;
                end else if (out_col_reg + 1'b1 >= w_eff) begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + 1'b1;
                    out_line_reg <= line_inc(out_line_reg);
                end else begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            op_reg  <= s_op;
            pix_reg <= s_pixel_value;
        end
        if (state_reg == ST_CHECK) begin
            row_reg   <= ylo_c;
            yhi_reg   <= yhi_c;
            line_reg  <= start_line_c;
            col_reg   <= xlo_c;
            xlo_reg   <= xlo_c;
            xhi_reg   <= xhi_c;
            step2_reg <= ilace_reg;
        end
        if (state_reg == ST_DIST_T) begin
            t_reg <= t_prod[RECIP_SHIFT +: T_W];
        end
        if (state_reg == ST_DIST_SQ) begin
            sq_reg <= SQ_W'(t_reg) * SQ_W'(t_reg);
        end
        if (state_reg == ST_DIST_D3) begin
            v_reg    <= v_prod[RECIP_SHIFT +: V_W];
            dist_reg <= '0;
            bit_reg  <= 3'(DIST_W - 1);
        end
        // One result bit of the square root per cycle, from the top down.
        if (state_reg == ST_DIST_RT) begin
            if (trial_sq <= (2*DIST_W)'(v_reg)) begin
                dist_reg <= trial;
            end
            bit_reg <= bit_reg - 1'b1;
        end
        if (state_reg == ST_CTR_LAT) begin
            centre_reg <= rd_data;
            sum_reg    <= '0;
            cnt_reg    <= '0;
        end
        // Read issue walks the window; the data is accumulated in the cycle after the read.
        if (state_reg == ST_SCAN) begin
            if (col_reg == xhi_reg) begin
                col_reg  <= xlo_reg;
                row_reg  <= row_step;
                line_reg <= line_adv;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
        if (pend_reg && in_range) begin
            sum_reg <= sum_reg + SUM_W'(rd_data);
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_val_reg  <= div_quo[PIX_W-1:0];
            m_done_reg <= frame_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_value = m_val_reg;
    assign m_frame_done     = m_done_reg;

    // Scan addresses stay inside the clipped window.
    a_scan_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> (col_reg <= xhi_reg && row_reg <= yhi_reg))
        else $error("window scan left its bounds");

    // Ring line numbers never leave the ring.
    a_line_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_line_reg < LW'(RING)) && (out_line_reg < LW'(RING)))
        else $error("ring line number out of range");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider result arrived unexpectedly");

    // A result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_ready) |=> state_reg == ST_OUT)
        else $error("pending transaction overwritten");

    // The in-range count never exceeds the largest window, MAX_DIAMETER squared.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV_START |-> cnt_reg <= CNT_W'(CNT_MAX))
        else $error("window count exceeds the window size");

endmodule

FILE: src/sf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; used for the line store of the sigma filter.
module sf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/sf_div.sv
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on nothing; instantiated by the sigma filter top level.
module sf_div #(
    parameter int NUM_W = 15,
    parameter int DEN_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] step_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_shift;
    logic             fits;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        rem_shift = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out at the top while quotient bits enter below.
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule
